@@ sv/cbmf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbmf_pkg
// Shared constants and helpers for the complex binary matched filter.
// ----------------------------------------------------------------------------
package cbmf_pkg;

   // Width of one result component and of a code mask register.
   localparam int OUT_W      = 23;
   localparam int MASK_W     = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Taps folded into one partial sum, and partial sums folded per tree level.
   localparam int TAP_GROUP = 4;
   localparam int SUM_FAN   = 8;

   // Register indexes, taken from paddr bit 2.
   localparam logic REG_I_CODE = 1'b0;
   localparam logic REG_Q_CODE = 1'b1;

   localparam logic [MASK_W-1:0] I_CODE_RESET = 32'hE307_A73A;
   localparam logic [MASK_W-1:0] Q_CODE_RESET = 32'h285A_57AB;

   // Taps past the end of the mask always use a coefficient of plus one.
   function automatic logic code_negative(input logic [MASK_W-1:0] mask, input int k);
      logic neg;
      if (k < MASK_W) begin
         neg = mask[k[4:0]];
      end else begin
         neg = 1'b0;
      end
      return neg;
   endfunction

endpackage
`default_nettype wire

@@ sv/cbmf_csr.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbmf_csr
// Register file for the two code sign masks behind a simple APB-style port.
// ----------------------------------------------------------------------------
module cbmf_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [cbmf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [cbmf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic      [cbmf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                                  csr_pready,
   output logic      [cbmf_pkg::MASK_W-1:0]      i_mask,
   output logic      [cbmf_pkg::MASK_W-1:0]      q_mask
);
   import cbmf_pkg::*;

   logic [MASK_W-1:0] i_mask_ff;
   logic [MASK_W-1:0] q_mask_ff;
   logic              wr_en;
   logic              reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         i_mask_ff <= I_CODE_RESET;
         q_mask_ff <= Q_CODE_RESET;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_I_CODE: i_mask_ff <= csr_pwdata;
            REG_Q_CODE: q_mask_ff <= csr_pwdata;
            default:    i_mask_ff <= i_mask_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_I_CODE: csr_prdata = i_mask_ff;
         REG_Q_CODE: csr_prdata = q_mask_ff;
         default:    csr_prdata = '0;
      endcase
   end

   assign i_mask = i_mask_ff;
   assign q_mask = q_mask_ff;

endmodule
`default_nettype wire

@@ sv/cbmf_delay_line.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbmf_delay_line
// Shift register of samples; the newest sample sits at tap 0.
// ----------------------------------------------------------------------------
module cbmf_delay_line #(
   parameter int TAPS        = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          shift_en,
   input  wire logic [SAMPLE_BITS-1:0]        sample,
   output logic signed [SAMPLE_BITS-1:0]      taps [TAPS]
);
   import cbmf_pkg::*;

   logic signed [SAMPLE_BITS-1:0] taps_ff [TAPS];
   logic signed [SAMPLE_BITS-1:0] taps_in [TAPS];

   always_comb begin
      taps_in[0] = sample;
      for (int k = 1; k < TAPS; k++) begin
         taps_in[k] = taps_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TAPS; k++) begin
            taps_ff[k] <= '0;
         end
      end else if (shift_en) begin
         taps_ff <= taps_in;
      end
   end

   assign taps = taps_ff;

endmodule
`default_nettype wire

@@ sv/cbmf_tap_sum.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbmf_tap_sum
// Applies the code signs to both delay lines and sums small groups of taps
// into registered partial X and Y values.
// ----------------------------------------------------------------------------
module cbmf_tap_sum #(
   parameter int TAPS        = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   enable,
   input  wire logic signed [SAMPLE_BITS-1:0]          i_taps [TAPS],
   input  wire logic signed [SAMPLE_BITS-1:0]          q_taps [TAPS],
   input  wire logic [cbmf_pkg::MASK_W-1:0]            i_mask,
   input  wire logic [cbmf_pkg::MASK_W-1:0]            q_mask,
   output logic signed [SAMPLE_BITS+3:0]               x_part [(TAPS+cbmf_pkg::TAP_GROUP-1)/cbmf_pkg::TAP_GROUP],
   output logic signed [SAMPLE_BITS+3:0]               y_part [(TAPS+cbmf_pkg::TAP_GROUP-1)/cbmf_pkg::TAP_GROUP]
);
   import cbmf_pkg::*;

   localparam int NG     = (TAPS + TAP_GROUP - 1) / TAP_GROUP;
   localparam int PART_W = SAMPLE_BITS + 4;

   logic signed [PART_W-1:0] x_part_ff [NG];
   logic signed [PART_W-1:0] y_part_ff [NG];
   logic signed [PART_W-1:0] x_part_in [NG];
   logic signed [PART_W-1:0] y_part_in [NG];

   always_comb begin
      logic signed [PART_W-1:0] ie;
      logic signed [PART_W-1:0] qe;
      logic signed [PART_W-1:0] x_acc;
      logic signed [PART_W-1:0] y_acc;
      logic                     neg_i;
      logic                     neg_q;
      int                       k;
      for (int g = 0; g < NG; g++) begin
         x_acc = '0;
         y_acc = '0;
         for (int j = 0; j < TAP_GROUP; j++) begin
            k = g * TAP_GROUP + j;
            if (k < TAPS) begin
               ie    = PART_W'(i_taps[k]);
               qe    = PART_W'(q_taps[k]);
               neg_i = code_negative(i_mask, k);
               neg_q = code_negative(q_mask, k);
               // X gets I*cI + Q*cQ, Y gets Q*cI - I*cQ.
               x_acc = x_acc + (neg_i ? -ie : ie) + (neg_q ? -qe : qe);
               y_acc = y_acc + (neg_i ? -qe : qe) + (neg_q ? ie : -ie);
            end
         end
         x_part_in[g] = x_acc;
         y_part_in[g] = y_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_part_ff <= x_part_in;
         y_part_ff <= y_part_in;
      end
   end

   assign x_part = x_part_ff;
   assign y_part = y_part_ff;

endmodule
`default_nettype wire

@@ sv/cbmf_sum_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbmf_sum_stage
// One registered level of an adder tree: folds groups of FAN signed inputs
// into one wider sum each.
// ----------------------------------------------------------------------------
module cbmf_sum_stage #(
   parameter int IN_N = 8,
   parameter int IN_W = 20,
   parameter int FAN  = 8
) (
   input  wire logic                                    clock,
   input  wire logic                                    enable,
   input  wire logic signed [IN_W-1:0]                  din  [IN_N],
   output logic signed [IN_W+$clog2(FAN)-1:0]           dout [(IN_N+FAN-1)/FAN]
);
   import cbmf_pkg::*;

   localparam int OUT_N = (IN_N + FAN - 1) / FAN;
   localparam int OUT_W = IN_W + $clog2(FAN);

   logic signed [OUT_W-1:0] sum_ff [OUT_N];
   logic signed [OUT_W-1:0] sum_in [OUT_N];

   always_comb begin
      logic signed [OUT_W-1:0] acc;
      int                      idx;
      for (int o = 0; o < OUT_N; o++) begin
         acc = '0;
         for (int f = 0; f < FAN; f++) begin
            idx = o * FAN + f;
            if (idx < IN_N) begin
               acc = acc + OUT_W'(din[idx]);
            end
         end
         sum_in[o] = acc;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sum_ff <= sum_in;
      end
   end

   assign dout = sum_ff;

endmodule
`default_nettype wire

@@ sv/complex_binary_matched_filter.sv @@
`default_nettype none
// A sample transfer is registered in turn by the delay line, the signed tap
// groups, the tree level and the final sum / output register, which presents
// the result. Throughput: one I/Q pair per cycle; the whole pipeline holds
// while a result waits on rsp_tready. Reset clears both delay lines to zero,
// empties the pipeline and loads the code masks with their default patterns.
// ----------------------------------------------------------------------------
// complex_binary_matched_filter
// Complex correlator of I/Q samples against two +1/-1 code patterns.
// ----------------------------------------------------------------------------
module complex_binary_matched_filter #(
   parameter int TAPS        = 32,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   // req_tdata: i_sample, q_sample (SAMPLE_BITS each), zero padding
   input  wire logic                                     req_tvalid,
   output logic                                          req_tready,
   input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]       req_tdata,
   // rsp_tdata: x_out[22:0], y_out[45:23], zero padding
   output logic                                          rsp_tvalid,
   input  wire logic                                     rsp_tready,
   output logic [47:0]                                   rsp_tdata,
   input  wire logic                                     csr_psel,
   input  wire logic                                     csr_penable,
   input  wire logic                                     csr_pwrite,
   input  wire logic [cbmf_pkg::CSR_ADDR_W-1:0]          csr_paddr,
   input  wire logic [cbmf_pkg::CSR_DATA_W-1:0]          csr_pwdata,
   output logic      [cbmf_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                          csr_pready
);
   import cbmf_pkg::*;

   localparam int NG1    = (TAPS + TAP_GROUP - 1) / TAP_GROUP;
   localparam int PART_W = SAMPLE_BITS + 4;
   localparam int NG2    = (NG1 + SUM_FAN - 1) / SUM_FAN;
   localparam int MID_W  = PART_W + $clog2(SUM_FAN);
   localparam int FIN_W  = MID_W + $clog2(NG2);
   localparam int EXT_W  = (FIN_W > OUT_W) ? FIN_W : OUT_W;

   logic [MASK_W-1:0] i_mask;
   logic [MASK_W-1:0] q_mask;

   logic signed [SAMPLE_BITS-1:0] i_taps [TAPS];
   logic signed [SAMPLE_BITS-1:0] q_taps [TAPS];
   logic signed [PART_W-1:0]      x_part [NG1];
   logic signed [PART_W-1:0]      y_part [NG1];
   logic signed [MID_W-1:0]       x_mid  [NG2];
   logic signed [MID_W-1:0]       y_mid  [NG2];
   logic signed [FIN_W-1:0]       x_fin  [1];
   logic signed [FIN_W-1:0]       y_fin  [1];
   logic signed [EXT_W-1:0]       x_ext;
   logic signed [EXT_W-1:0]       y_ext;

   // Valid bits for the delay line, tap sum and tree level stages, and the
   // output register.
   logic tap_vld_ff;
   logic part_vld_ff;
   logic mid_vld_ff;
   logic out_vld_ff;
   logic advance;
   logic accept;

   // Every stage moves together unless a finished result is still waiting.
   assign advance    = ~out_vld_ff | rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid & advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_vld_ff  <= 1'b0;
         part_vld_ff <= 1'b0;
         mid_vld_ff  <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else if (advance) begin
         tap_vld_ff  <= req_tvalid;
         part_vld_ff <= tap_vld_ff;
         mid_vld_ff  <= part_vld_ff;
         out_vld_ff  <= mid_vld_ff;
      end
   end

   cbmf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .i_mask      (i_mask),
      .q_mask      (q_mask)
   );

   cbmf_delay_line #(
      .TAPS        (TAPS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_i_line (
      .clock    (clock),
      .reset    (reset),
      .shift_en (accept),
      .sample   (req_tdata[SAMPLE_BITS-1:0]),
      .taps     (i_taps)
   );

   cbmf_delay_line #(
      .TAPS        (TAPS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_q_line (
      .clock    (clock),
      .reset    (reset),
      .shift_en (accept),
      .sample   (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .taps     (q_taps)
   );

   cbmf_tap_sum #(
      .TAPS        (TAPS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_tap_sum (
      .clock  (clock),
      .enable (advance),
      .i_taps (i_taps),
      .q_taps (q_taps),
      .i_mask (i_mask),
      .q_mask (q_mask),
      .x_part (x_part),
      .y_part (y_part)
   );

   cbmf_sum_stage #(
      .IN_N (NG1),
      .IN_W (PART_W),
      .FAN  (SUM_FAN)
   ) u_x_mid (
      .clock  (clock),
      .enable (advance),
      .din    (x_part),
      .dout   (x_mid)
   );

   cbmf_sum_stage #(
      .IN_N (NG1),
      .IN_W (PART_W),
      .FAN  (SUM_FAN)
   ) u_y_mid (
      .clock  (clock),
      .enable (advance),
      .din    (y_part),
      .dout   (y_mid)
   );

   // The last tree level doubles as the output register.
   cbmf_sum_stage #(
      .IN_N (NG2),
      .IN_W (MID_W),
      .FAN  (NG2)
   ) u_x_fin (
      .clock  (clock),
      .enable (advance),
      .din    (x_mid),
      .dout   (x_fin)
   );

   cbmf_sum_stage #(
      .IN_N (NG2),
      .IN_W (MID_W),
      .FAN  (NG2)
   ) u_y_fin (
      .clock  (clock),
      .enable (advance),
      .din    (y_mid),
      .dout   (y_fin)
   );

   // Results wrap to the 23-bit output width.
   assign x_ext = EXT_W'(x_fin[0]);
   assign y_ext = EXT_W'(y_fin[0]);

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {2'b00, y_ext[OUT_W-1:0], x_ext[OUT_W-1:0]};

endmodule
`default_nettype wire

@@ test/cbmf_correlation_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cbmf_correlation_checker
// Watches the sample, result and register ports of the complex binary matched
// filter. It keeps its own I and Q delay lines and code masks, works out the
// expected X/Y pair for every sample transfer and compares each result
// transfer, field by field, with the oldest pair still waiting.
// ----------------------------------------------------------------------------
module cbmf_correlation_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   // req_tdata: i_sample[15:0], q_sample[31:16]
   input  wire logic [31:0]                     req_tdata,
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   // rsp_tdata: x_out[22:0], y_out[45:23], zero padding
   input  wire logic [47:0]                     rsp_tdata,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [cbmf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [cbmf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  wire logic [cbmf_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  wire logic                            csr_pready,
   output int                                   mismatch_count,
   output int                                   pending
);
   import cbmf_pkg::*;

   localparam int TAPS = 32;

   typedef logic [TAPS-1:0][15:0] sample_line_type;

   typedef struct packed {
      logic [OUT_W-1:0] x;
      logic [OUT_W-1:0] y;
   } corr_pair_type;

   sample_line_type   i_line;
   sample_line_type   q_line;
   logic [MASK_W-1:0] i_code;
   logic [MASK_W-1:0] q_code;
   corr_pair_type     expected_pairs[$];

   // A set mask bit flips the sign of that tap; taps past the mask add.
   function automatic logic signed [31:0] correlate_line(input sample_line_type line,
                                                         input logic [MASK_W-1:0] code);
      logic signed [31:0] acc;
      logic signed [31:0] tap;
      int k;
      acc = 0;
      for (k = 0; k < TAPS; k++) begin
         tap = {{16{line[k][15]}}, line[k]};
         if (k < MASK_W && code[k]) begin
            acc = acc - tap;
         end else begin
            acc = acc + tap;
         end
      end
      return acc;
   endfunction

   initial mismatch_count = 0;

   always @(posedge clock) begin
      sample_line_type    next_i;
      sample_line_type    next_q;
      logic signed [31:0] x_full;
      logic signed [31:0] y_full;
      logic [MASK_W-1:0]  reg_value;
      corr_pair_type      want;
      corr_pair_type      got;
      if (reset) begin
         i_line <= '0;
         q_line <= '0;
         i_code <= I_CODE_RESET;
         q_code <= Q_CODE_RESET;
         expected_pairs.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               case (csr_paddr[2])
                  REG_I_CODE: i_code <= csr_pwdata;
                  REG_Q_CODE: q_code <= csr_pwdata;
               endcase
            end else begin
               reg_value = (csr_paddr[2] == REG_Q_CODE) ? q_code : i_code;
               if (csr_prdata !== reg_value) begin
                  $error("%s: expected %h, got %h",
                         (csr_paddr[2] == REG_Q_CODE) ? "q_code_negative_mask"
                                                      : "i_code_negative_mask",
                         reg_value, csr_prdata);
                  mismatch_count++;
               end
            end
         end

         if (rsp_tvalid && rsp_tready) begin
            got.x = rsp_tdata[22:0];
            got.y = rsp_tdata[45:23];
            if (expected_pairs.size() == 0) begin
               $error("rsp transfer with no result expected: x_out %0d, y_out %0d",
                      $signed(got.x), $signed(got.y));
               mismatch_count++;
            end else begin
               want = expected_pairs.pop_front();
               if (got.x !== want.x) begin
                  $error("x_out: expected %0d, got %0d", $signed(want.x), $signed(got.x));
                  mismatch_count++;
               end
               if (got.y !== want.y) begin
                  $error("y_out: expected %0d, got %0d", $signed(want.y), $signed(got.y));
                  mismatch_count++;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            next_i = {i_line[TAPS-2:0], req_tdata[15:0]};
            next_q = {q_line[TAPS-2:0], req_tdata[31:16]};
            x_full = correlate_line(next_i, i_code) + correlate_line(next_q, q_code);
            y_full = correlate_line(next_q, i_code) - correlate_line(next_i, q_code);
            want.x = x_full[OUT_W-1:0];
            want.y = y_full[OUT_W-1:0];
            expected_pairs.push_back(want);
            i_line <= next_i;
            q_line <= next_q;
         end
      end
      pending <= expected_pairs.size();
   end

endmodule
`default_nettype wire

@@ test/complex_binary_matched_filter_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// complex_binary_matched_filter_tb
// Drives I/Q sample streams through the matched filter under a series of code
// mask settings, with random gaps on the sample side and random back-pressure
// on the result side. Checking is left to the correlation checker.
// ----------------------------------------------------------------------------
module complex_binary_matched_filter_tb;
   import cbmf_pkg::*;

   localparam int RANDOM_ITEMS = 1650;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;

   typedef enum int {FILL_UNIFORM, FILL_EDGES, FILL_SMALL, FILL_HELD} fill_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [31:0]           req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [47:0]           rsp_tdata;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int mismatch_count;
   int pending;
   int idle_cycles = 0;
   int ready_left  = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   complex_binary_matched_filter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   cbmf_correlation_checker corr_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .mismatch_count(mismatch_count),
      .pending       (pending)
   );

   // Result side: runs of ready, short and long stalls, and now and then a
   // long stretch with no back-pressure at all.
   always @(posedge clock) begin
      int r;
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_left <= 0;
      end else if (ready_left == 0) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            rsp_tready <= 1'b1;
            ready_left <= $urandom_range(1, 12);
         end else if (r < 90) begin
            rsp_tready <= 1'b0;
            ready_left <= $urandom_range(1, 3);
         end else if (r < 97) begin
            rsp_tready <= 1'b0;
            ready_left <= $urandom_range(15, 50);
         end else begin
            rsp_tready <= 1'b1;
            ready_left <= $urandom_range(100, 300);
         end
      end else begin
         ready_left <= ready_left - 1;
      end
   end

   // Ends the run if the channels go quiet for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("complex_binary_matched_filter_tb: done, errors");
            $finish;
         end
      end
   end

   function automatic int pick_gap(input bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 65) begin
         return 0;
      end else if (r < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [15:0] edge_sample();
      case ($urandom_range(0, 4))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'hFFFF;
         3:       return 16'h0001;
         default: return 16'h0000;
      endcase
   endfunction

   function automatic logic [15:0] pick_sample(input fill_type fill, input logic [15:0] held);
      case (fill)
         FILL_UNIFORM: return 16'($urandom);
         FILL_EDGES:   return edge_sample();
         FILL_SMALL:   return 16'($urandom_range(0, 16)) - 16'd8;
         default:      return held;
      endcase
   endfunction

   function automatic logic [MASK_W-1:0] pick_mask(input logic [MASK_W-1:0] default_mask);
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return default_mask;
         3:       return 32'h5555_5555;
         default: return $urandom;
      endcase
   endfunction

   // The transfer happens at the first edge with tready high; a gap lowers
   // tvalid afterwards, otherwise the next pair follows back to back.
   task automatic send_iq_pair(input logic [15:0] i_s, input logic [15:0] q_s,
                               input int gap);
      req_tvalid <= 1'b1;
      req_tdata  <= {q_s, i_s};
      do @(posedge clock); while (!req_tready);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic csr_access(input logic reg_idx, input logic is_write,
                             input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= {reg_idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Code masks change only once every result is out and the pipeline is empty.
   task automatic load_code_masks(input logic [MASK_W-1:0] i_mask,
                                  input logic [MASK_W-1:0] q_mask);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_access(REG_I_CODE, 1'b1, i_mask);
      csr_access(REG_Q_CODE, 1'b1, q_mask);
      csr_access(REG_I_CODE, 1'b0, '0);
      csr_access(REG_Q_CODE, 1'b0, '0);
   endtask

   initial begin
      logic [15:0] dir_i[14];
      logic [15:0] dir_q[14];
      logic [15:0] held_i;
      logic [15:0] held_q;
      fill_type    fill;
      bit          quiet;
      int          phase;
      int          phase_len;
      int          sent;
      int          gap;
      int          r;
      int          n;

      dir_i = '{16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
                16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF, 16'h8001, 16'h1234, 16'h0000};
      dir_q = '{16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001,
                16'hAAAA, 16'h5555, 16'hFFFF, 16'h0000, 16'h7FFE, 16'hEDCB, 16'h0000};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pairs under the default masks, straight after reset.
      for (n = 0; n < 14; n++) begin
         send_iq_pair(dir_i[n], dir_q[n], (n == 13) ? 1 : pick_gap(n < 7));
      end

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         // The first four phases hold the most negative sample against all-plus
         // and all-minus codes, which drives X and Y to both ends of their range.
         if (phase < 4) begin
            load_code_masks(phase[0] ? '1 : '0, phase[1] ? '1 : '0);
            fill      = FILL_HELD;
            held_i    = 16'h8000;
            held_q    = 16'h8000;
            phase_len = 40;
            quiet     = 1'b0;
         end else begin
            load_code_masks(pick_mask(I_CODE_RESET), pick_mask(Q_CODE_RESET));
            r = $urandom_range(0, 9);
            fill      = (r < 5) ? FILL_UNIFORM : (r < 7) ? FILL_EDGES
                      : (r < 9) ? FILL_SMALL : FILL_HELD;
            held_i    = edge_sample();
            held_q    = edge_sample();
            phase_len = $urandom_range(60, 160);
            quiet     = ($urandom_range(0, 3) == 0);
         end
         for (n = 0; n < phase_len; n++) begin
            gap = pick_gap(quiet);
            if (n == phase_len - 1) begin
               gap = gap + 1;
            end
            send_iq_pair(pick_sample(fill, held_i), pick_sample(fill, held_q), gap);
         end
         sent  = sent + phase_len;
         phase = phase + 1;
      end

      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("complex_binary_matched_filter_tb: done, clean");
      end else begin
         $display("complex_binary_matched_filter_tb: done, errors");
      end
      $finish;
   end

endmodule
`default_nettype wire
